### rtl/fpc_pkg.sv
// Package holding the shared types and codes of the frustum plane culling core.
`timescale 1ns / 1ps
package fpc_pkg;

    // Item kinds on the input channel.
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_COMPUTE = 3'd1;
    localparam logic [2:0] KIND_POINT   = 3'd2;
    localparam logic [2:0] KIND_SPHERE  = 3'd3;
    localparam logic [2:0] KIND_BOX     = 3'd4;

    // Answer kinds on the output channel.
    localparam logic ANS_PLANES = 1'b0;
    localparam logic ANS_TEST   = 1'b1;

    // Number of frustum planes and index of the last one.
    localparam int unsigned PLANE_COUNT = 6;
    localparam logic [2:0]  LAST_PLANE  = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CRA,
        S_CRB,
        S_CADD,
        S_CSQ,
        S_CSTART,
        S_CSQRT,
        S_CDS,
        S_CDIV,
        S_CWR,
        S_TRA,
        S_TRD,
        S_TMUL,
        S_TCHK,
        S_DONE
    } t_state;

    // Request to the serial square root and divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_su_req;

endpackage

### rtl/fpc_serial_unit.sv
// Bit-serial integer square root and restoring divider, one step per cycle.
`timescale 1ns / 1ps
module fpc_serial_unit
    import fpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_su_req                 i_req,
    input  logic [63:0]             i_operand,
    input  logic [31:0]             i_divisor,
    output logic                    o_done,
    output logic [32+FRAC_BITS-1:0] o_result
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_is_div;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_n;
    logic [63:0]   r_root;
    logic [63:0]   r_bit;
    logic [31:0]   r_den;
    logic [32:0]   r_rem;
    logic [NW-1:0] r_quo;

    logic [63:0]   trial;
    logic [32:0]   rem_sh;

    assign trial  = r_root + r_bit;
    assign rem_sh = {r_rem[31:0], r_n[NW-1]};

    // Control: busy flag, step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.is_div ? CW'(NW) : CW'(32);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one root or quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_n      <= i_operand;
            r_root   <= '0;
            r_bit    <= 64'h4000_0000_0000_0000;
            r_den    <= i_divisor;
            r_rem    <= '0;
            r_quo    <= '0;
        end else if (r_busy) begin
            if (r_is_div) begin
                r_n <= {r_n[62:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
            end else begin
                if (r_n >= trial) begin
                    r_n    <= r_n - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? r_quo : {{(NW-32){1'b0}}, r_root[31:0]};

endmodule

### rtl/frustum_plane_cull_core.sv
// Top level of the frustum plane culling core: sequencer, stores and shared multiplier.
// Load items leave the sequencer idle; the input stalls while a compute or test item is
// worked on. Point and sphere tests check up to six planes, box tests up to eight corners
// per plane, using one 33 x 33 multiply-accumulate per cycle and one plane-store read per
// cycle. Plane computation time is set by the bit-serial square root and divider. A
// synchronous active-low reset empties both stores (they read as zero) and returns the
// sequencer to idle with no result pending.
`timescale 1ns / 1ps
module frustum_plane_cull_core
    import fpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic [1:0]         i_matrix_row,
    input  logic [1:0]         i_matrix_col,
    input  logic signed [31:0] i_matrix_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_radius,
    input  logic signed [31:0] i_half_x,
    input  logic signed [31:0] i_half_y,
    input  logic signed [31:0] i_half_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_answer_kind,
    output logic               o_inside_res,
    output logic               o_degenerate
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int AW = 72;

    // Sequencer registers.
    t_state r_state, n_state;
    logic [2:0] r_p, n_p;
    logic [1:0] r_k, n_k;
    logic [1:0] r_j, n_j;
    logic [2:0] r_c, n_c;
    logic r_deg, n_deg;
    logic r_inside, n_inside;
    logic r_is_test, n_is_test;

    // Working registers.
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_comp [4];
    logic signed [31:0] n_comp [4];
    logic signed [31:0] r_pl [4];
    logic signed [31:0] n_pl [4];
    logic [63:0] r_sq, n_sq;
    logic [31:0] r_len, n_len;
    logic [NW-1:0] r_q, n_q;
    logic signed [AW-1:0] r_acc, n_acc;

    // Captured item.
    logic [2:0] r_kind;
    logic signed [31:0] r_x, r_y, r_z, r_rad, r_hx, r_hy, r_hz;

    // Output register.
    logic r_out_valid, n_out_valid;
    logic r_ans_kind, n_ans_kind;
    logic r_ans_inside, n_ans_inside;
    logic r_ans_deg, n_ans_deg;

    // Stores.
    logic signed [31:0] r_mat [16];
    logic [15:0] r_mat_vld;
    logic signed [31:0] r_mat_q;
    logic r_mat_qv;
    logic [3:0] mat_raddr;
    logic signed [31:0] mat_val;

    logic signed [31:0] r_pls [24];
    logic [23:0] r_pls_vld;
    logic signed [31:0] r_pls_q;
    logic r_pls_qv;
    logic [4:0] pl_addr;
    logic pl_we;
    logic signed [31:0] pl_wdata;
    logic signed [31:0] pl_val;

    logic in_acc;
    logic out_acc;

    // Shared multiplier.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    // Serial unit.
    t_su_req su_req;
    logic [63:0] su_operand;
    logic su_done;
    logic [NW-1:0] su_result;

    // Combinational helpers.
    logic signed [32:0] sum33;
    logic signed [31:0] sat_sum;
    logic [31:0] comp_mag;
    logic signed [32:0] base_c, half_c, coord;
    logic signed [AW-1:0] lim;
    logic signed [AW-1:0] d_init_rd;
    logic signed [AW-1:0] d_init_reg;
    logic pass;
    logic signed [31:0] wb_val;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    assign mat_val = r_mat_qv ? r_mat_q : '0;
    assign pl_val  = r_pls_qv ? r_pls_q : '0;
    assign pl_addr = {r_p, r_k};

    assign prod = mul_a * mul_b;

    // Matrix store: element write on a load beat, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_LOAD)) begin
            r_mat[{i_matrix_row, i_matrix_col}] <= i_matrix_value;
        end
        r_mat_q  <= r_mat[mat_raddr];
        r_mat_qv <= r_mat_vld[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_vld <= '0;
        end else if (in_acc && (i_kind == KIND_LOAD)) begin
            r_mat_vld[{i_matrix_row, i_matrix_col}] <= 1'b1;
        end
    end

    // Plane store: one write and one registered read per cycle, both at the same address.
    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_pls[pl_addr] <= pl_wdata;
        end
        r_pls_q  <= r_pls[pl_addr];
        r_pls_qv <= r_pls_vld[pl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pls_vld <= '0;
        end else if (pl_we) begin
            r_pls_vld[pl_addr] <= 1'b1;
        end
    end

    // Item capture on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_rad  <= i_radius;
            r_hx   <= i_half_x;
            r_hy   <= i_half_y;
            r_hz   <= i_half_z;
        end
    end

    // Plane component: row 3 plus or minus the chosen row, saturated.
    always_comb begin
        sum33 = r_p[0] ? (33'(r_a) + 33'(mat_val)) : (33'(r_a) - 33'(mat_val));
        if (sum33[32] != sum33[31]) begin
            sat_sum = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_sum = sum33[31:0];
        end
    end

    // The square root takes the sum of squares; the divider takes the scaled magnitude.
    assign comp_mag = r_comp[r_k][31] ? (32'd0 - r_comp[r_k]) : r_comp[r_k];
    assign su_operand = (r_state == S_CSTART) ? r_sq
                                              : 64'({comp_mag, {FRAC_BITS{1'b0}}});

    // Normalized component: signed quotient saturated to 32 bits, or the raw component when the length is zero.
    always_comb begin
        if (r_len == '0) begin
            wb_val = r_comp[r_k];
        end else if (!r_comp[r_k][31]) begin
            wb_val = (r_q > NW'(33'h0_7fff_ffff)) ? 32'sh7fff_ffff : r_q[31:0];
        end else begin
            wb_val = (r_q > NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : (32'd0 - r_q[31:0]);
        end
    end

    // Corner coordinate for the current multiply step.
    always_comb begin
        case (r_j)
            2'd0: begin
                base_c = 33'(r_x);
                half_c = 33'(r_hx);
            end
            2'd1: begin
                base_c = 33'(r_y);
                half_c = 33'(r_hy);
            end
            default: begin
                base_c = 33'(r_z);
                half_c = 33'(r_hz);
            end
        endcase
        if (r_kind == KIND_BOX) begin
            coord = r_c[r_j] ? (base_c + half_c) : (base_c - half_c);
        end else begin
            coord = base_c;
        end
    end

    assign lim        = -(AW'(r_rad) <<< FRAC_BITS);
    assign d_init_rd  = AW'(pl_val) <<< FRAC_BITS;
    assign d_init_reg = AW'(r_pl[3]) <<< FRAC_BITS;
    assign pass       = (r_kind == KIND_SPHERE) ? (r_acc > lim) : (r_acc > AW'(0));

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_p          = r_p;
        n_k          = r_k;
        n_j          = r_j;
        n_c          = r_c;
        n_deg        = r_deg;
        n_inside     = r_inside;
        n_is_test    = r_is_test;
        n_a          = r_a;
        n_comp       = r_comp;
        n_pl         = r_pl;
        n_sq         = r_sq;
        n_len        = r_len;
        n_q          = r_q;
        n_acc        = r_acc;
        n_out_valid  = out_acc ? 1'b0 : r_out_valid;
        n_ans_kind   = r_ans_kind;
        n_ans_inside = r_ans_inside;
        n_ans_deg    = r_ans_deg;
        mat_raddr    = {2'd3, r_k};
        pl_we        = 1'b0;
        pl_wdata     = wb_val;
        su_req       = '{start: 1'b0, is_div: 1'b0};
        mul_a        = 33'(r_comp[r_k]);
        mul_b        = 33'(r_comp[r_k]);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_p = '0;
                    n_k = '0;
                    case (i_kind)
                        KIND_COMPUTE: begin
                            n_deg     = 1'b0;
                            n_is_test = 1'b0;
                            n_state   = S_CRA;
                        end
                        KIND_POINT, KIND_SPHERE, KIND_BOX: begin
                            n_is_test = 1'b1;
                            n_state   = S_TRA;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Plane forming: read row 3 then the paired row.
            S_CRA: begin
                mat_raddr = {2'd3, r_k};
                n_state   = S_CRB;
            end
            S_CRB: begin
                n_a       = mat_val;
                mat_raddr = {r_p[2:1], r_k};
                n_state   = S_CADD;
            end
            S_CADD: begin
                n_comp[r_k] = sat_sum;
                if (r_k == 2'd3) begin
                    n_k     = '0;
                    n_sq    = '0;
                    n_state = S_CSQ;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_CRA;
                end
            end

            // Sum of squares of the normal, one square per cycle.
            S_CSQ: begin
                n_sq = r_sq + prod[63:0];
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_CSTART;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_CSTART: begin
                su_req  = '{start: 1'b1, is_div: 1'b0};
                n_state = S_CSQRT;
            end
            S_CSQRT: begin
                if (su_done) begin
                    n_len   = su_result[31:0];
                    n_state = S_CDS;
                end
            end

            // Normalization, one component at a time.
            S_CDS: begin
                if (r_len == '0) begin
                    n_state = S_CWR;
                end else begin
                    su_req  = '{start: 1'b1, is_div: 1'b1};
                    n_state = S_CDIV;
                end
            end
            S_CDIV: begin
                if (su_done) begin
                    n_q     = su_result;
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                pl_we = 1'b1;
                if (r_k == 2'd3) begin
                    n_deg = r_deg | (r_len == '0);
                    n_k   = '0;
                    if (r_p == LAST_PLANE) begin
                        n_state = S_DONE;
                    end else begin
                        n_p     = r_p + 3'd1;
                        n_state = S_CRA;
                    end
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_CDS;
                end
            end

            // Test: fetch the four plane components.
            S_TRA: begin
                n_state = S_TRD;
            end
            S_TRD: begin
                n_pl[r_k] = pl_val;
                if (r_k == 2'd3) begin
                    n_acc   = d_init_rd;
                    n_j     = '0;
                    n_c     = '0;
                    n_state = S_TMUL;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_TRA;
                end
            end

            // Dot product, one term per cycle.
            S_TMUL: begin
                mul_a = 33'(r_pl[r_j]);
                mul_b = coord;
                n_acc = r_acc + AW'(prod);
                if (r_j == 2'd2) begin
                    n_state = S_TCHK;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            S_TCHK: begin
                n_j = '0;
                if (pass) begin
                    if (r_p == LAST_PLANE) begin
                        n_inside = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_p     = r_p + 3'd1;
                        n_k     = '0;
                        n_state = S_TRA;
                    end
                end else if ((r_kind == KIND_BOX) && (r_c != 3'd7)) begin
                    n_c     = r_c + 3'd1;
                    n_acc   = d_init_reg;
                    n_state = S_TMUL;
                end else begin
                    n_inside = 1'b0;
                    n_state  = S_DONE;
                end
            end

            // Hand the answer to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_ans_kind   = r_is_test ? ANS_TEST : ANS_PLANES;
                    n_ans_inside = r_is_test & r_inside;
                    n_ans_deg    = !r_is_test & r_deg;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_p         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_c         <= '0;
            r_deg       <= 1'b0;
            r_inside    <= 1'b0;
            r_is_test   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_p         <= n_p;
            r_k         <= n_k;
            r_j         <= n_j;
            r_c         <= n_c;
            r_deg       <= n_deg;
            r_inside    <= n_inside;
            r_is_test   <= n_is_test;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_comp       <= n_comp;
        r_pl         <= n_pl;
        r_sq         <= n_sq;
        r_len        <= n_len;
        r_q          <= n_q;
        r_acc        <= n_acc;
        r_ans_kind   <= n_ans_kind;
        r_ans_inside <= n_ans_inside;
        r_ans_deg    <= n_ans_deg;
    end

    fpc_serial_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (su_req),
        .i_operand (su_operand),
        .i_divisor (r_len),
        .o_done    (su_done),
        .o_result  (su_result)
    );

    assign o_valid       = r_out_valid;
    assign o_answer_kind = r_ans_kind;
    assign o_inside_res  = r_ans_inside;
    assign o_degenerate  = r_ans_deg;

endmodule

### rtl/fpc_checker.sv
// Port-level checker for the frustum plane culling core and its bind.
`timescale 1ns / 1ps
module fpc_checker
    import fpc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [2:0] i_kind,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_answer_kind,
    input logic       o_inside_res,
    input logic       o_degenerate
);

    // A stalled result beat stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped under stall");

    // A plane computation answer never reports inside.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_answer_kind == ANS_PLANES) |-> !o_inside_res)
        else $error("plane answer with inside set");

    // A test answer never reports a degenerate plane.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_answer_kind == ANS_TEST) |-> !o_degenerate)
        else $error("test answer with degenerate set");

    // A load beat leaves the input unstalled in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == KIND_LOAD) |=> !o_stall)
        else $error("input stalled after a load beat");

    // Compute and test beats occupy the core.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && ((i_kind == KIND_COMPUTE) || (i_kind == KIND_POINT) ||
        (i_kind == KIND_SPHERE) || (i_kind == KIND_BOX)) |=> o_stall)
        else $error("input not stalled after a work beat");

endmodule

bind frustum_plane_cull_core fpc_checker u_fpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_answer_kind (o_answer_kind),
    .o_inside_res  (o_inside_res),
    .o_degenerate  (o_degenerate)
);
